// ===== hdl/ptw_pkg.sv =====
package ptw_pkg;

  localparam int TIME_W     = 48;
  localparam int INTERVAL_W = 32;
  localparam int ID_W       = 6;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // response status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // what the output register is loaded with
  typedef enum logic [2:0] {
    SEL_ADD_OK,
    SEL_ZERO,
    SEL_FULL,
    SEL_CANCEL,
    SEL_NONE,
    SEL_PEND
  } sel_t;

  typedef struct packed {
    logic accept;       // request item taken, latch operands
    logic now_adv;      // tick: advance time
    logic idx_inc;      // step timer index
    logic ram_rd;       // read entry at index
    logic mod_start;    // start interval mod SLOTS
    logic add_commit;   // arm timer at index
    logic cancel_do;    // free timer_id
    logic fire_commit;  // re-arm timer at index, make it pending
    logic out_load;     // load output register
    sel_t out_sel;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic int_zero;
    logic slot_free;
    logic idx_last;
    logic mod_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/ptw_ram.sv =====
module ptw_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ptw_rem.sv =====
// Interval mod SLOTS by reciprocal multiplication. The low quotient bits are
// registered on start; rem is valid from done on while din holds.
module ptw_rem #(
  parameter int SLOTS = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ptw_pkg::INTERVAL_W-1:0]     din,
  output logic                               done,
  output logic [$clog2(SLOTS)-1:0]           rem
);

  localparam int XW  = ptw_pkg::INTERVAL_W;
  localparam int SW  = $clog2(SLOTS);
  localparam int MW  = XW + 1;
  localparam int PRW = XW + MW;
  // ceil(2^(XW+SW) / SLOTS) gives the exact quotient for every XW-bit input
  localparam logic [63:0] RECIP =
    ((64'd1 << (XW + SW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [SW-1:0] SLOTS_LO = SW'(SLOTS);

  logic [PRW-1:0] prod;
  logic [SW-1:0]  quo_lo;
  logic [SW-1:0]  back;

  assign prod = PRW'(din) * PRW'(RECIP[MW-1:0]);

  // only the low SW bits of quotient * SLOTS matter, the remainder is < SLOTS
  assign back = quo_lo * SLOTS_LO;
  assign rem  = din[SW-1:0] - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_lo <= prod[XW+SW +: SW];
    end
  end

endmodule

// ===== hdl/ptw_datapath.sv =====
module ptw_datapath #(
  parameter int SLOTS  = 256,
  parameter int TIMERS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ptw_pkg::cmd_t                    cmd,
  output ptw_pkg::stat_t                   stat,
  input  logic [ptw_pkg::INTERVAL_W-1:0]   interval,
  input  logic [ptw_pkg::ID_W-1:0]         timer_id,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic [ptw_pkg::STATUS_W-1:0]     status,
  output logic [ptw_pkg::ID_W-1:0]         result_id,
  output logic                             fired,
  output logic                             last
);

  localparam int TW = ptw_pkg::TIME_W;
  localparam int PW = ptw_pkg::INTERVAL_W;
  localparam int SW = $clog2(SLOTS);
  localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int EW = PW + TW + 2 * SW;

  // 2^48 mod SLOTS, and the correction applied to a slot sum when time wraps
  localparam logic [63:0] WRAP_REM = 64'h0001_0000_0000_0000 % SLOTS;
  localparam logic [63:0] WRAP_ADJ = (64'(SLOTS) - WRAP_REM) % SLOTS;

  logic [TW-1:0]      now;
  logic [SW-1:0]      now_slot;
  logic [TIMERS-1:0]  active;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      pend_id;
  logic               pend_valid;
  logic [PW-1:0]      interval_q;
  logic [ptw_pkg::ID_W-1:0] tid_q;

  logic [EW-1:0]      rd_data;
  logic [EW-1:0]      wr_data;
  logic [SW-1:0]      rd_eslot;
  logic [TW-1:0]      rd_expiry;
  logic [SW-1:0]      rd_pslot;
  logic [PW-1:0]      rd_period;

  logic [PW-1:0]      op_period;
  logic [SW-1:0]      op_pslot;
  logic [TW:0]        exp_sum;
  logic [SW-1:0]      exp_slot;
  logic [SW-1:0]      mod_rem;
  logic               mod_done;

  // (a + b + wrap correction) mod SLOTS for a, b below SLOTS
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a,
                                             input logic [SW-1:0] b,
                                             input logic wrap);
    logic [SW+1:0] s;
    s = {2'b00, a} + {2'b00, b} + (wrap ? (SW+2)'(WRAP_ADJ) : '0);
    if (s >= (SW+2)'(2 * SLOTS)) begin
      s = s - (SW+2)'(2 * SLOTS);
    end else if (s >= (SW+2)'(SLOTS)) begin
      s = s - (SW+2)'(SLOTS);
    end
    return s[SW-1:0];
  endfunction

  assign rd_eslot  = rd_data[SW-1:0];
  assign rd_expiry = rd_data[SW +: TW];
  assign rd_pslot  = rd_data[SW+TW +: SW];
  assign rd_period = rd_data[2*SW+TW +: PW];

  assign op_period = cmd.add_commit ? interval_q : rd_period;
  assign op_pslot  = cmd.add_commit ? mod_rem : rd_pslot;
  assign exp_sum   = {1'b0, now} + {{(TW+1-PW){1'b0}}, op_period};
  assign exp_slot  = slot_add(now_slot, op_pslot, exp_sum[TW]);
  assign wr_data   = {op_period, op_pslot, exp_sum[TW-1:0], exp_slot};

  ptw_ram #(
    .WIDTH (EW),
    .DEPTH (TIMERS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.add_commit | cmd.fire_commit),
    .waddr (idx),
    .wdata (wr_data),
    .re    (cmd.ram_rd),
    .raddr (idx),
    .rdata (rd_data)
  );

  ptw_rem #(
    .SLOTS (SLOTS)
  ) u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .din   (interval_q),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    stat.int_zero   = (interval_q == '0);
    stat.slot_free  = !active[idx];
    stat.idx_last   = (idx == IW'(TIMERS - 1));
    stat.mod_done   = mod_done;
    stat.hit        = active[idx] && (rd_eslot == now_slot) && (rd_expiry <= now);
    stat.pend_valid = pend_valid;
    stat.out_free   = !rsp_valid || rsp_ready;
  end

  // time, active bits, scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      now        <= '0;
      now_slot   <= '0;
      active     <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.now_adv) begin
        now <= now + 1'b1;
        if (now == '1 || now_slot == SW'(SLOTS - 1)) begin
          now_slot <= '0;
        end else begin
          now_slot <= now_slot + 1'b1;
        end
      end
      if (cmd.accept) begin
        pend_valid <= 1'b0;
      end else if (cmd.fire_commit) begin
        pend_valid <= 1'b1;
      end
      if (cmd.add_commit) begin
        active[idx] <= 1'b1;
      end
      if (cmd.cancel_do && ({1'b0, tid_q} < (ptw_pkg::ID_W+1)'(TIMERS))) begin
        active[tid_q[IW-1:0]] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      interval_q <= interval;
      tid_q      <= timer_id;
      idx        <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.fire_commit) begin
      pend_id <= idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      last <= cmd.out_last;
      case (cmd.out_sel)
        ptw_pkg::SEL_ADD_OK: begin
          status    <= ptw_pkg::ST_OK;
          result_id <= ptw_pkg::ID_W'(idx);
          fired     <= 1'b0;
        end
        ptw_pkg::SEL_ZERO: begin
          status    <= ptw_pkg::ST_ZERO;
          result_id <= '0;
          fired     <= 1'b0;
        end
        ptw_pkg::SEL_FULL: begin
          status    <= ptw_pkg::ST_FULL;
          result_id <= '0;
          fired     <= 1'b0;
        end
        ptw_pkg::SEL_CANCEL: begin
          status    <= ptw_pkg::ST_OK;
          result_id <= tid_q;
          fired     <= 1'b0;
        end
        ptw_pkg::SEL_PEND: begin
          status    <= ptw_pkg::ST_OK;
          result_id <= ptw_pkg::ID_W'(pend_id);
          fired     <= 1'b1;
        end
        default: begin
          status    <= ptw_pkg::ST_OK;
          result_id <= '0;
          fired     <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ptw_ctrl.sv =====
module ptw_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic [ptw_pkg::KIND_W-1:0]   kind,
  output logic                         req_ready,
  input  ptw_pkg::stat_t               stat,
  output ptw_pkg::cmd_t                cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_CHK,
    S_ADD_FIND,
    S_ADD_MOD,
    S_CANCEL,
    S_EMIT,
    S_T_READ,
    S_T_CHK,
    S_T_END
  } state_t;

  state_t         state;
  state_t         state_next;
  ptw_pkg::sel_t  sel;
  ptw_pkg::sel_t  sel_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd        = '0;
    cmd.out_sel = ptw_pkg::SEL_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (kind)
            ptw_pkg::KIND_ADD:    state_next = S_ADD_CHK;
            ptw_pkg::KIND_CANCEL: state_next = S_CANCEL;
            ptw_pkg::KIND_TICK: begin
              cmd.now_adv = 1'b1;
              state_next  = S_T_READ;
            end
            default: begin
              sel_next   = ptw_pkg::SEL_NONE;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_ADD_CHK: begin
        if (stat.int_zero) begin
          sel_next   = ptw_pkg::SEL_ZERO;
          state_next = S_EMIT;
        end else begin
          state_next = S_ADD_FIND;
        end
      end
      S_ADD_FIND: begin
        if (stat.slot_free) begin
          cmd.mod_start = 1'b1;
          state_next    = S_ADD_MOD;
        end else if (stat.idx_last) begin
          sel_next   = ptw_pkg::SEL_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_ADD_MOD: begin
        if (stat.mod_done) begin
          cmd.add_commit = 1'b1;
          sel_next       = ptw_pkg::SEL_ADD_OK;
          state_next     = S_EMIT;
        end
      end
      S_CANCEL: begin
        cmd.cancel_do = 1'b1;
        sel_next      = ptw_pkg::SEL_CANCEL;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = sel;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_T_READ: begin
        cmd.ram_rd = 1'b1;
        state_next = S_T_CHK;
      end
      S_T_CHK: begin
        // a new hit pushes the previous one out; wait if it cannot leave
        if (!(stat.hit && stat.pend_valid && !stat.out_free)) begin
          if (stat.hit) begin
            cmd.fire_commit = 1'b1;
            if (stat.pend_valid) begin
              cmd.out_load = 1'b1;
              cmd.out_sel  = ptw_pkg::SEL_PEND;
            end
          end
          if (stat.idx_last) begin
            state_next = S_T_END;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_T_READ;
          end
        end
      end
      S_T_END: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stat.pend_valid ? ptw_pkg::SEL_PEND : ptw_pkg::SEL_NONE;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= ptw_pkg::SEL_NONE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

endmodule

// ===== hdl/periodic_timer_wheel_top.sv =====
// Periodic timer wheel: a pool of TIMERS periodic timers hashed into SLOTS
// wheel slots by expiry time.
// Request channel (req_valid/req_ready, kind/interval/timer_id):
//   add    - arms the lowest free timer, expiry = now + interval; one response
//            with the id, or status zero-interval / pool-full.
//   cancel - frees timer_id; one response echoing timer_id.
//   tick   - advances time by one and fires every active timer whose expiry
//            falls on the new slot and is not in the future; each one is
//            re-armed at now + period. One response per fired id, ascending,
//            last set on the final one; a single empty response if none fire.
// Response channel (rsp_valid/rsp_ready, status/result_id/fired/last) is fed
// from one output register, so a new request is taken while a final
// response still waits there.
// Timing: one request at a time; the next is taken the cycle after the final
// response is loaded. An add goes through the check, find, mod and emit states,
// find stepping over each busy id below the free one; a cancel through the
// cancel and emit states; a tick takes each timer entry through a RAM read
// state and a compare/re-arm state. A stalled response port stalls the scan.
// Reset: time is zero and all timers are free; entry RAM needs no clearing.
module periodic_timer_wheel_top #(
  parameter int SLOTS  = 256,
  parameter int TIMERS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [ptw_pkg::KIND_W-1:0]         kind,
  input  logic [ptw_pkg::INTERVAL_W-1:0]     interval,
  input  logic [ptw_pkg::ID_W-1:0]           timer_id,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output logic [ptw_pkg::STATUS_W-1:0]       status,
  output logic [ptw_pkg::ID_W-1:0]           result_id,
  output logic                               fired,
  output logic                               last
);

  ptw_pkg::cmd_t  cmd;
  ptw_pkg::stat_t stat;

  // sequencing of add search, cancel and tick scan
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .kind      (kind),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // time, active bits, entry RAM, slot math and output register
  ptw_datapath #(
    .SLOTS  (SLOTS),
    .TIMERS (TIMERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .interval  (interval),
    .timer_id  (timer_id),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .status    (status),
    .result_id (result_id),
    .fired     (fired),
    .last      (last)
  );

endmodule
